// File: rtl/pbs_pkg.sv
// shared types and constants of the pixel stack bias statistics block
`timescale 1ns / 1ps
`default_nettype none
package pbs_pkg;
   localparam int PIXELS      = 4096;
   localparam int PIX_W       = $clog2(PIXELS);
   localparam int MAX_FRAMES  = 1024;
   localparam int CNT_W       = 11;
   localparam int SMP_W       = 24;
   localparam int SQR_W       = 48;
   localparam int SUM_W       = 34;
   localparam int SSQ_W       = 58;
   localparam int ENT_W       = SUM_W + SSQ_W + CNT_W;
   localparam int FILL_W      = 16;
   localparam int FRAC_W      = 8;
   localparam int DVS_W       = 20;
   localparam int DIV_W       = 69;
   localparam int ISQ_W       = 64;
   localparam int DIV_STEPS   = DIV_W;
   localparam int SQRT_STEPS  = ISQ_W / 2;
   localparam int MUL_STEPS   = SUM_W;
   localparam int STEP_W      = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic ACT_ACCUMULATE = 1'b0;
   localparam logic ACT_READOUT    = 1'b1;
   localparam logic CSR_IDX_FILL   = 1'b0;

   typedef struct packed {
      logic                    action;
      logic [PIX_W-1:0]        pixel;
      logic signed [SMP_W-1:0] sample;
      logic [SQR_W-1:0]        square;
   } item_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;
endpackage
`default_nettype wire

// File: rtl/pbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/pbs_front.sv
// front end: accepts transactions, drops fill samples, squares, queues
`timescale 1ns / 1ps
`default_nettype none
module pbs_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_action,
   input  wire logic [pbs_pkg::PIX_W-1:0]       req_pixel_index,
   input  wire logic signed [pbs_pkg::SMP_W-1:0] req_sample_value,
   input  wire logic signed [pbs_pkg::FILL_W-1:0] fill_value,
   input  wire pbs_pkg::back_status_type        status,
   input  wire logic                            pop,
   output pbs_pkg::item_type                    head,
   output logic                                 head_valid
);
   import pbs_pkg::*;

   item_type                 q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [FILL_W-1:0] int_part;
   logic signed [SQR_W-1:0]  sq_full;
   logic                     drop, push, do_pop;
   item_type                 entry;

   // integer part truncated toward zero
   assign int_part = req_sample_value[SMP_W-1 -: FILL_W]
                   + FILL_W'(req_sample_value[SMP_W-1] && (|req_sample_value[FRAC_W-1:0]));
   assign drop = (req_action == ACT_ACCUMULATE) && (int_part == fill_value);
   assign sq_full = req_sample_value * req_sample_value;

   assign req_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH)) && !status.clearing;
   assign push       = req_valid && req_ready && !drop;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      entry.action = req_action;
      entry.pixel  = req_pixel_index;
      entry.sample = req_sample_value;
      entry.square = sq_full;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end
endmodule
`default_nettype wire

// File: rtl/pbs_back.sv
// back end: per-pixel store update and sequential readout arithmetic
`timescale 1ns / 1ps
`default_nettype none
module pbs_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pbs_pkg::item_type                 head,
   input  wire logic                              head_valid,
   output logic                                   pop,
   output pbs_pkg::back_status_type               status,
   input  wire logic signed [pbs_pkg::FILL_W-1:0] fill_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [pbs_pkg::PIX_W-1:0]              rsp_out_pixel,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_mean_value,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_rms_value,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_std_dev,
   output logic [pbs_pkg::CNT_W-1:0]              rsp_sample_count,
   output logic                                   rsp_no_data
);
   import pbs_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_ACC   = 12'b000000000100,
      ST_LOAD  = 12'b000000001000,
      ST_DMEAN = 12'b000000010000,
      ST_DSQ   = 12'b000000100000,
      ST_SRMS  = 12'b000001000000,
      ST_MULN  = 12'b000010000000,
      ST_MULS  = 12'b000100000000,
      ST_DSD   = 12'b001000000000,
      ST_SSD   = 12'b010000000000,
      ST_EMIT  = 12'b100000000000
   } state_type;

   localparam logic [ISQ_W-1:0] SAT_MAX = ISQ_W'((1 << (SMP_W - 1)) - 1);

   function automatic logic [SMP_W-1:0] sat24(input logic [ISQ_W-1:0] v);
      sat24 = (v > SAT_MAX) ? SAT_MAX[SMP_W-1:0] : v[SMP_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [PIX_W-1:0]        clr_ff, clr_in;
   item_type                item_ff, item_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SSQ_W-1:0]        sq_ff, sq_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [DVS_W-1:0]        nn_ff, nn_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [DIV_W-1:0]        divq_ff, divq_in;
   logic [DVS_W-1:0]        divr_ff, divr_in, dvs_ff, dvs_in;
   logic [ISQ_W-1:0]        sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [DIV_W-1:0]        macc_ff, macc_in, mcand_ff, mcand_in, prod_ff, prod_in;
   logic [SUM_W-1:0]        mplr_ff, mplr_in;
   logic [SMP_W-1:0]        mean_ff, mean_in, rms_ff, rms_in, sd_ff, sd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]        rsp_pix_ff, rsp_pix_in;
   logic [SMP_W-1:0]        rsp_mean_ff, rsp_mean_in, rsp_rms_ff, rsp_rms_in;
   logic [SMP_W-1:0]        rsp_sd_ff, rsp_sd_in;
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_nd_ff, rsp_nd_in;

   logic                    wr_en;
   logic [PIX_W-1:0]        wr_addr, rd_addr;
   logic [ENT_W-1:0]        wr_data, rd_data;
   logic signed [SUM_W-1:0] rd_sum, smp_ext;
   logic [SSQ_W-1:0]        rd_sq;
   logic [CNT_W-1:0]        rd_cnt;
   logic [SUM_W-1:0]        rd_abs, sum_abs;
   logic [2*CNT_W-1:0]      nn_full;
   logic [DVS_W:0]          rem_try, rem_new;
   logic                    rem_ge;
   logic [DIV_W-1:0]        divq_next;
   logic [ISQ_W-1:0]        s_t, sx_next, sres_next;
   logic                    s_ge;
   logic [DIV_W-1:0]        macc_next;
   logic [SMP_W-1:0]        q24;
   logic                    rsp_free, last_div, last_sqrt, last_mul;
   logic [SMP_W-1:0]        fill_scaled;

   pbs_ram #(.WIDTH(ENT_W), .DEPTH(PIXELS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_sum  = rd_data[ENT_W-1 -: SUM_W];
   assign rd_sq   = rd_data[CNT_W +: SSQ_W];
   assign rd_cnt  = rd_data[CNT_W-1:0];
   assign rd_abs  = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign smp_ext = {{(SUM_W-SMP_W){item_ff.sample[SMP_W-1]}}, item_ff.sample};
   assign nn_full = {{CNT_W{1'b0}}, rd_cnt} * {{CNT_W{1'b0}}, rd_cnt - 1'b1};
   assign fill_scaled = {fill_value, {FRAC_W{1'b0}}};

   // restoring divide, one quotient bit per cycle
   assign rem_try   = {divr_ff, divq_ff[DIV_W-1]};
   assign rem_ge    = rem_try >= {1'b0, dvs_ff};
   assign rem_new   = rem_ge ? rem_try - {1'b0, dvs_ff} : rem_try;
   assign divq_next = {divq_ff[DIV_W-2:0], rem_ge};
   assign q24       = divq_next[SMP_W-1:0];

   // digit by digit square root, two radicand bits per cycle
   assign s_t       = sres_ff + sbit_ff;
   assign s_ge      = sx_ff >= s_t;
   assign sx_next   = s_ge ? sx_ff - s_t : sx_ff;
   assign sres_next = s_ge ? (sres_ff >> 1) + sbit_ff : sres_ff >> 1;

   // shift and add multiply
   assign macc_next = mplr_ff[0] ? macc_ff + mcand_ff : macc_ff;

   assign last_div  = step_ff == STEP_W'(DIV_STEPS - 1);
   assign last_sqrt = step_ff == STEP_W'(SQRT_STEPS - 1);
   assign last_mul  = step_ff == STEP_W'(MUL_STEPS - 1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign status.clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      item_in     = item_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      n_in        = n_ff;
      nn_in       = nn_ff;
      step_in     = step_ff;
      divq_in     = divq_ff;
      divr_in     = divr_ff;
      dvs_in      = dvs_ff;
      sx_in       = sx_ff;
      sres_in     = sres_ff;
      sbit_in     = sbit_ff;
      macc_in     = macc_ff;
      mcand_in    = mcand_ff;
      mplr_in     = mplr_ff;
      prod_in     = prod_ff;
      mean_in     = mean_ff;
      rms_in      = rms_ff;
      sd_in       = sd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in  = rsp_pix_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_rms_in  = rsp_rms_ff;
      rsp_sd_in   = rsp_sd_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_nd_in   = rsp_nd_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = item_ff.pixel;
      wr_data     = '0;
      rd_addr     = head.pixel;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == PIX_W'(PIXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               item_in  = head;
               state_in = (head.action == ACT_READOUT) ? ST_LOAD : ST_ACC;
            end
         end
         ST_ACC: begin
            if (rd_cnt < CNT_W'(MAX_FRAMES)) begin
               wr_en   = 1'b1;
               wr_data = {rd_sum + smp_ext,
                          rd_sq + SSQ_W'(item_ff.square),
                          rd_cnt + 1'b1};
            end
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            wr_en  = 1'b1;
            sum_in = rd_sum;
            sq_in  = rd_sq;
            n_in   = rd_cnt;
            nn_in  = nn_full[DVS_W-1:0];
            if (rd_cnt == '0) begin
               mean_in  = fill_scaled;
               rms_in   = fill_scaled;
               sd_in    = fill_scaled;
               state_in = ST_EMIT;
            end else begin
               divq_in  = DIV_W'(rd_abs);
               divr_in  = '0;
               dvs_in   = DVS_W'(rd_cnt);
               step_in  = '0;
               state_in = ST_DMEAN;
            end
         end
         ST_DMEAN: begin
            divq_in = divq_next;
            divr_in = rem_new[DVS_W-1:0];
            step_in = step_ff + 1'b1;
            if (last_div) begin
               mean_in  = sum_ff[SUM_W-1] ? ~q24 + 1'b1 : q24;
               divq_in  = DIV_W'(sq_ff);
               divr_in  = '0;
               dvs_in   = DVS_W'(n_ff);
               step_in  = '0;
               state_in = ST_DSQ;
            end
         end
         ST_DSQ: begin
            divq_in = divq_next;
            divr_in = rem_new[DVS_W-1:0];
            step_in = step_ff + 1'b1;
            if (last_div) begin
               sx_in    = divq_next[ISQ_W-1:0];
               sres_in  = '0;
               sbit_in  = {2'b01, {(ISQ_W-2){1'b0}}};
               step_in  = '0;
               state_in = ST_SRMS;
            end
         end
         ST_SRMS: begin
            sx_in   = sx_next;
            sres_in = sres_next;
            sbit_in = sbit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (last_sqrt) begin
               rms_in  = sat24(sres_next);
               step_in = '0;
               if (n_ff == CNT_W'(1)) begin
                  sd_in    = '0;
                  state_in = ST_EMIT;
               end else begin
                  macc_in  = '0;
                  mcand_in = DIV_W'(sq_ff);
                  mplr_in  = SUM_W'(n_ff);
                  state_in = ST_MULN;
               end
            end
         end
         ST_MULN: begin
            macc_in  = macc_next;
            mcand_in = mcand_ff << 1;
            mplr_in  = mplr_ff >> 1;
            step_in  = step_ff + 1'b1;
            if (last_mul) begin
               prod_in  = macc_next;
               macc_in  = '0;
               mcand_in = DIV_W'(sum_abs);
               mplr_in  = sum_abs;
               step_in  = '0;
               state_in = ST_MULS;
            end
         end
         ST_MULS: begin
            macc_in  = macc_next;
            mcand_in = mcand_ff << 1;
            mplr_in  = mplr_ff >> 1;
            step_in  = step_ff + 1'b1;
            if (last_mul) begin
               divq_in  = prod_ff - macc_next;
               divr_in  = '0;
               dvs_in   = nn_ff;
               step_in  = '0;
               state_in = ST_DSD;
            end
         end
         ST_DSD: begin
            divq_in = divq_next;
            divr_in = rem_new[DVS_W-1:0];
            step_in = step_ff + 1'b1;
            if (last_div) begin
               sx_in    = divq_next[ISQ_W-1:0];
               sres_in  = '0;
               sbit_in  = {2'b01, {(ISQ_W-2){1'b0}}};
               step_in  = '0;
               state_in = ST_SSD;
            end
         end
         ST_SSD: begin
            sx_in   = sx_next;
            sres_in = sres_next;
            sbit_in = sbit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (last_sqrt) begin
               sd_in    = sat24(sres_next);
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = item_ff.pixel;
               rsp_mean_in  = mean_ff;
               rsp_rms_in   = rms_ff;
               rsp_sd_in    = sd_ff;
               rsp_cnt_in   = n_ff;
               rsp_nd_in    = (n_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      sum_ff      <= sum_in;
      sq_ff       <= sq_in;
      n_ff        <= n_in;
      nn_ff       <= nn_in;
      step_ff     <= step_in;
      divq_ff     <= divq_in;
      divr_ff     <= divr_in;
      dvs_ff      <= dvs_in;
      sx_ff       <= sx_in;
      sres_ff     <= sres_in;
      sbit_ff     <= sbit_in;
      macc_ff     <= macc_in;
      mcand_ff    <= mcand_in;
      mplr_ff     <= mplr_in;
      prod_ff     <= prod_in;
      mean_ff     <= mean_in;
      rms_ff      <= rms_in;
      sd_ff       <= sd_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_rms_ff  <= rsp_rms_in;
      rsp_sd_ff   <= rsp_sd_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_nd_ff   <= rsp_nd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_pixel    = rsp_pix_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_rms_value    = rsp_rms_ff;
   assign rsp_std_dev      = rsp_sd_ff;
   assign rsp_sample_count = rsp_cnt_ff;
   assign rsp_no_data      = rsp_nd_ff;
endmodule
`default_nettype wire

// File: rtl/pixel_stack_bias_statistics_top.sv
// top level of the pixel stack bias statistics block
`timescale 1ns / 1ps
`default_nettype none
// Keeps a running sum, sum of squares and sample count for each of 4096 pixels
// in one 103-bit wide memory; an accumulate transaction takes the back end
// through a memory read, then a write back; fill samples are dropped in the
// front end without reaching the queue. A readout runs through one shared
// shift-subtract divider, a radix-4 square root and a shift-add multiplier;
// a single sample skips the multiplier, the last division and the second
// square root, and an empty pixel skips all of them. After reset a clearing
// pass writes zero to every pixel, during which no transaction is taken.
// A two-entry queue and the result register let input and output stall apart.
module pixel_stack_bias_statistics_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [pbs_pkg::PIX_W-1:0]         req_pixel_index,
   input  wire logic signed [pbs_pkg::SMP_W-1:0]  req_sample_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [pbs_pkg::PIX_W-1:0]              rsp_out_pixel,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_mean_value,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_rms_value,
   output logic signed [pbs_pkg::SMP_W-1:0]       rsp_std_dev,
   output logic [pbs_pkg::CNT_W-1:0]              rsp_sample_count,
   output logic                                   rsp_no_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pbs_pkg::CSR_AW-1:0]        paddr,
   input  wire logic [pbs_pkg::CSR_DW-1:0]        pwdata,
   output logic [pbs_pkg::CSR_DW-1:0]             prdata,
   output logic                                   pready
);
   import pbs_pkg::*;

   logic signed [FILL_W-1:0] fill_ff, fill_in;
   logic                     csr_hit, csr_wr;
   back_status_type          status;
   item_type                 head;
   logic                     head_valid, pop;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_AW-1:2] == CSR_IDX_FILL);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign fill_in = csr_wr ? pwdata[FILL_W-1:0] : fill_ff;
   assign prdata  = csr_hit ? {{(CSR_DW-FILL_W){fill_ff[FILL_W-1]}}, fill_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   pbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_pixel_index  (req_pixel_index),
      .req_sample_value (req_sample_value),
      .fill_value       (fill_ff),
      .status           (status),
      .pop              (pop),
      .head             (head),
      .head_valid       (head_valid)
   );

   pbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .pop              (pop),
      .status           (status),
      .fill_value       (fill_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_rms_value    (rsp_rms_value),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_no_data      (rsp_no_data)
   );

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> status.clearing)
      else $error("clearing pass not started after reset");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_valid && !head_valid)
      else $error("activity during clearing pass");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count <= CNT_W'(MAX_FRAMES))
                    && (rsp_no_data == (rsp_sample_count == '0)))
      else $error("result count out of range or no data flag wrong");
endmodule
`default_nettype wire

// File: tb/tb_pixel_stack_bias_statistics_top.sv
// testbench of the pixel stack bias statistics block: random and directed transactions, scoreboard
`timescale 1ns / 1ps
module tb_pixel_stack_bias_statistics_top;
   import pbs_pkg::*;

   typedef struct {
      logic              action;
      logic [PIX_W-1:0]  pixel;
      logic [SMP_W-1:0]  sample;
   } pixel_op_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [SMP_W-1:0]  mean;
      logic [SMP_W-1:0]  rms;
      logic [SMP_W-1:0]  dev;
      logic [CNT_W-1:0]  count;
      logic              no_data;
   } pixel_stats_type;

   logic clock, reset;
   logic req_valid, req_ready, req_action;
   logic [PIX_W-1:0] req_pixel_index;
   logic signed [SMP_W-1:0] req_sample_value;
   logic rsp_valid, rsp_ready;
   logic [PIX_W-1:0] rsp_out_pixel;
   logic signed [SMP_W-1:0] rsp_mean_value, rsp_rms_value, rsp_std_dev;
   logic [CNT_W-1:0] rsp_sample_count;
   logic rsp_no_data;
   logic psel, penable, pwrite, pready;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata, prdata;

   pixel_stack_bias_statistics_top dut (.*);

   pixel_op_type    pending_ops[$];
   pixel_stats_type expected_stats[$];
   longint          pix_sum[PIXELS];
   logic [63:0]     pix_sqsum[PIXELS];
   int              pix_count[PIXELS];
   longint          fill_marker;
   int              errors;
   bit              no_idle;
   bit              req_fire;
   int              req_gap, rsp_gap;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic [SMP_W-1:0] sat24(logic [63:0] v);
      return (v > 64'd8388607) ? 24'd8388607 : v[SMP_W-1:0];
   endfunction

   // updates the per-pixel sums; returns 1 with the statistics on a readout
   function automatic bit update_pixel(pixel_op_type op, output pixel_stats_type st);
      longint s, sum, n;
      logic [63:0] sq;
      logic [127:0] nsq, sum2, diff, quo;
      logic [63:0] asum;
      int p;
      p = op.pixel;
      s = longint'(signed'(op.sample));
      st = '0;
      if (op.action == ACT_ACCUMULATE) begin
         if (s / 256 == fill_marker || pix_count[p] >= MAX_FRAMES) return 0;
         pix_sum[p] += s;
         pix_sqsum[p] += 64'(s * s);
         pix_count[p]++;
         return 0;
      end
      n = pix_count[p];
      sum = pix_sum[p];
      sq = pix_sqsum[p];
      st.pixel = op.pixel;
      st.count = CNT_W'(n);
      if (n == 0) begin
         st.mean = SMP_W'(fill_marker * 256);
         st.rms = st.mean;
         st.dev = st.mean;
         st.no_data = 1;
      end else begin
         st.mean = SMP_W'(sum / n);
         st.rms = sat24(isqrt(sq / 64'(n)));
         if (n == 1) begin
            st.dev = 0;
         end else begin
            asum = (sum < 0) ? 64'(-sum) : 64'(sum);
            nsq = 128'(n) * 128'(sq);
            sum2 = 128'(asum) * 128'(asum);
            diff = nsq - sum2;
            quo = diff / (128'(n) * 128'(n - 1));
            st.dev = sat24(isqrt(quo[63:0]));
         end
      end
      pix_sum[p] = 0;
      pix_sqsum[p] = 0;
      pix_count[p] = 0;
      return 1;
   endfunction

   // input driver
   always @(negedge clock) begin
      logic v;
      pixel_op_type op;
      v = req_valid;
      if (reset) begin
         v = 0;
         req_gap = 0;
      end else begin
         if (v && req_fire) v = 0;
         if (!v) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops.pop_front();
               req_action <= op.action;
               req_pixel_index <= op.pixel;
               req_sample_value <= op.sample;
               v = 1;
               req_gap = pick_gap();
            end
         end
      end
      req_valid <= v;
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         rsp_gap = pick_gap();
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      pixel_op_type op;
      pixel_stats_type st, got;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         op.action = req_action;
         op.pixel = req_pixel_index;
         op.sample = req_sample_value;
         if (update_pixel(op, st)) expected_stats.push_back(st);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_pixel, rsp_mean_value, rsp_rms_value, rsp_std_dev,
                 rsp_sample_count, rsp_no_data};
         if (expected_stats.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction: pixel %0d mean %0d", $time,
                     got.pixel, signed'(got.mean));
         end else begin
            st = expected_stats.pop_front();
            if (got !== st) begin
               errors++;
               $display("%0t mismatch expected pix %0d mean %0d rms %0d dev %0d n %0d nd %0b",
                        $time, st.pixel, signed'(st.mean), st.rms, st.dev, st.count,
                        st.no_data);
               $display("%0t          actual   pix %0d mean %0d rms %0d dev %0d n %0d nd %0b",
                        $time, got.pixel, signed'(got.mean), got.rms, got.dev, got.count,
                        got.no_data);
            end
         end
      end
   end

   task automatic csr_write(logic [FILL_W-1:0] value);
      @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= CSR_AW'(4 * CSR_IDX_FILL);
      pwdata <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      fill_marker = longint'(signed'(value));
   endtask

   task automatic push_op(logic action, int pixel, int sample);
      pixel_op_type op;
      op.action = action;
      op.pixel = PIX_W'(pixel);
      op.sample = SMP_W'(sample);
      pending_ops.push_back(op);
   endtask

   task automatic drain();
      wait (pending_ops.size() == 0 && !req_valid && expected_stats.size() == 0);
      repeat (400) @(posedge clock);
   endtask

   // sample whose integer part matches the current marker
   function automatic int marker_sample();
      int f;
      f = $urandom_range(255);
      if (fill_marker == -32768) f = 0;
      return (fill_marker >= 0) ? int'(fill_marker) * 256 + f : int'(fill_marker) * 256 - f;
   endfunction

   task automatic random_ops(int count, int window);
      int base, pix, r, smp;
      base = $urandom_range(PIXELS - 1);
      for (int i = 0; i < count; i++) begin
         pix = ($urandom_range(7) == 0) ? $urandom_range(PIXELS - 1)
                                         : (base + $urandom_range(window - 1)) % PIXELS;
         r = $urandom_range(7);
         if (r == 0) smp = marker_sample();
         else if (r < 3) smp = $urandom_range(4000) - 2000;
         else smp = $urandom;
         push_op(($urandom_range(5) == 0) ? ACT_READOUT : ACT_ACCUMULATE, pix, smp);
      end
   endtask

   initial begin
      errors = 0;
      fill_marker = 0;
      no_idle = 0;
      req_fire = 0;
      req_gap = 0;
      rsp_gap = 0;
      for (int i = 0; i < PIXELS; i++) begin
         pix_sum[i] = 0;
         pix_sqsum[i] = 0;
         pix_count[i] = 0;
      end
      req_valid = 0;
      req_action = 0;
      req_pixel_index = 0;
      req_sample_value = 0;
      rsp_ready = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      csr_write(16'sd0);
      push_op(ACT_READOUT, 0, 0);
      push_op(ACT_ACCUMULATE, 1, 8388607);
      push_op(ACT_READOUT, 1, 0);
      push_op(ACT_ACCUMULATE, 2, -8388608);
      push_op(ACT_ACCUMULATE, 2, -8388608);
      push_op(ACT_READOUT, 2, 0);
      push_op(ACT_ACCUMULATE, 3, 8388607);
      push_op(ACT_ACCUMULATE, 3, -8388608);
      push_op(ACT_ACCUMULATE, 3, 8388607);
      push_op(ACT_READOUT, 3, 0);
      push_op(ACT_ACCUMULATE, 4, 255);
      push_op(ACT_ACCUMULATE, 4, -255);
      push_op(ACT_ACCUMULATE, 4, 256);
      push_op(ACT_READOUT, 4, 0);
      push_op(ACT_ACCUMULATE, 4095, -1234);
      push_op(ACT_ACCUMULATE, 4095, 5000);
      push_op(ACT_READOUT, 4095, 0);
      drain();

      csr_write(-16'sd32768);
      push_op(ACT_READOUT, 10, 0);
      push_op(ACT_ACCUMULATE, 10, -8388608);
      push_op(ACT_ACCUMULATE, 10, -8388353);
      push_op(ACT_READOUT, 10, 0);
      drain();

      csr_write(16'sd32767);
      push_op(ACT_READOUT, 11, 0);
      push_op(ACT_ACCUMULATE, 11, 8388607);
      push_op(ACT_ACCUMULATE, 11, 8388352);
      push_op(ACT_READOUT, 11, 0);
      drain();

      // full pixel: samples past the frame limit are dropped
      csr_write(FILL_W'($urandom_range(80) - 40));
      for (int i = 0; i < 1030; i++) push_op(ACT_ACCUMULATE, 7, $urandom);
      push_op(ACT_READOUT, 7, 0);
      random_ops(150, 8);
      drain();

      no_idle = 1;
      csr_write(16'sd0);
      random_ops(150, 16);
      drain();
      no_idle = 0;

      csr_write(FILL_W'($urandom));
      random_ops(200, 4);
      drain();

      csr_write(-16'sd32768);
      random_ops(150, 32);
      drain();

      csr_write(16'sd32767);
      random_ops(150, 8);
      drain();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
